>>> rtl/lfr_pkg.sv
// Shared constants, codes, types and the delivery function of the frame router.
// Used by lfr_table, lfr_ctrl and learning_frame_router; depends on nothing.
package lfr_pkg;

  // Sizing of the route table and the link set.
  localparam int ROUTES    = 16;
  localparam int LINKS     = 8;
  localparam int ADDR_BITS = 32;

  localparam int SLOT_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int ADDR_W  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int PADDR_W = 5;

  // Link number that stands for no link at all.
  localparam logic [3:0] NO_LINK = 4'(LINKS);

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_SEND  = 2'd1,
    OP_TICK  = 2'd2,
    OP_ROUTE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_LOCAL = 2'd2,
    ACT_DROP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    DROP_NONE      = 3'd0,
    DROP_NO_ROUTE  = 3'd1,
    DROP_HOP_LIMIT = 3'd2,
    DROP_LINK_DOWN = 3'd3,
    DROP_TOO_LARGE = 3'd4
  } drop_e;

  typedef enum logic [1:0] {
    RT_OK      = 2'd0,
    RT_BAD_ARG = 2'd1,
    RT_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_LOCAL_ADDR   = 3'd0,
    REG_LEARN_ENABLE = 3'd1,
    REG_MAX_HOPS     = 3'd2,
    REG_ROUTE_TTL    = 3'd3,
    REG_DEFAULT_LINK = 3'd4,
    REG_UPLINK_MASK  = 3'd5,
    REG_LINK_COUNT   = 3'd6,
    REG_MTU_BYTES    = 3'd7
  } reg_e;

  // Configuration register file as seen by the sequencer.
  typedef struct packed {
    logic [31:0] local_addr;
    logic        learn_enable;
    logic [7:0]  max_hops;
    logic [31:0] route_ttl_ms;
    logic [3:0]  default_link;
    logic [7:0]  uplink_mask;
    logic [3:0]  link_count;
    logic [9:0]  mtu_bytes;
  } cfg_t;

  // One result item.
  typedef struct packed {
    action_e     action;
    logic [2:0]  out_link;
    logic [7:0]  out_hops;
    drop_e       drop_reason;
    logic        learned;
    logic [3:0]  learned_slot;
    logic        table_full;
    status_e     route_status;
  } res_t;

  // One table entry as read at the scan slot.
  typedef struct packed {
    logic              used;
    logic              is_static;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        link;
    logic [31:0]       seen;
  } tbl_rd_t;

  // Write command to the table, with an enable for each field.
  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] slot;
    logic              wr_used;
    logic              used;
    logic              wr_static;
    logic              is_static;
    logic              wr_addr;
    logic [ADDR_W-1:0] addr;
    logic              wr_link;
    logic [2:0]        link;
    logic              wr_seen;
    logic [31:0]       seen;
  } tbl_wr_t;

  // Sends a frame on the chosen link, or drops it when the link is missing,
  // down, or the payload exceeds the MTU.
  function automatic res_t deliver(input logic [3:0] target, input logic [7:0] hops,
                                   input logic [9:0] len, input logic [7:0] up,
                                   input cfg_t cfg, input res_t base);
    res_t r;
    r = base;
    if (target >= NO_LINK || target >= cfg.link_count) begin
      r.action      = ACT_DROP;
      r.drop_reason = DROP_NO_ROUTE;
    end else if (!up[target[2:0]]) begin
      r.action      = ACT_DROP;
      r.drop_reason = DROP_LINK_DOWN;
    end else if (len > cfg.mtu_bytes) begin
      r.action      = ACT_DROP;
      r.drop_reason = DROP_TOO_LARGE;
    end else begin
      r.action   = ACT_SEND;
      r.out_link = target[2:0];
      r.out_hops = hops;
    end
    return r;
  endfunction

endpackage

>>> rtl/lfr_table.sv
// Route table storage: used marks with reset, other fields written before use.
// Read at the scan slot, written through one port; depends on lfr_pkg.
module lfr_table
  import lfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output tbl_rd_t           rd_o,
  input  tbl_wr_t           wr_i
);

  logic              used_q   [ROUTES];
  logic              static_q [ROUTES];
  logic [ADDR_W-1:0] addr_q   [ROUTES];
  logic [2:0]        link_q   [ROUTES];
  logic [31:0]       seen_q   [ROUTES];

  // Used marks clear at reset so the table starts empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROUTES; i++) used_q[i] <= 1'b0;
    end else if (wr_i.wr && wr_i.wr_used) begin
      used_q[wr_i.slot] <= wr_i.used;
    end
  end

  // Entry contents are only read behind a set used mark.
  always_ff @(posedge clk_i) begin
    if (wr_i.wr) begin
      if (wr_i.wr_static) static_q[wr_i.slot] <= wr_i.is_static;
      if (wr_i.wr_addr)   addr_q[wr_i.slot]   <= wr_i.addr;
      if (wr_i.wr_link)   link_q[wr_i.slot]   <= wr_i.link;
      if (wr_i.wr_seen)   seen_q[wr_i.slot]   <= wr_i.seen;
    end
  end

  // Single read at the slot under scan.
  always_comb begin
    rd_o.used      = used_q[rd_slot_i];
    rd_o.is_static = static_q[rd_slot_i];
    rd_o.addr      = addr_q[rd_slot_i];
    rd_o.link      = link_q[rd_slot_i];
    rd_o.seen      = seen_q[rd_slot_i];
  end

endmodule

>>> rtl/lfr_ctrl.sv
// Sequencer of the frame router: scans the table one slot a cycle through one
// compare and age unit, then forms the result and the table update; uses lfr_pkg.
module lfr_ctrl
  import lfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [31:0]       dest_addr_i,
  input  logic [2:0]        ingress_link_i,
  input  logic [7:0]        hop_count_i,
  input  logic              upstream_i,
  input  logic [9:0]        payload_len_i,
  input  logic [31:0]       now_ms_i,
  input  logic [7:0]        links_up_i,
  input  logic [3:0]        route_link_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic [SLOT_W-1:0] rd_slot_o,
  input  tbl_rd_t           rd_i,
  output tbl_wr_t           wr_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q;
  logic              accept;
  logic              last;

  // Latched item.
  op_e               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        ingress_q;
  logic [7:0]        hops_q;
  logic              upstream_q;
  logic [9:0]        len_q;
  logic [31:0]       now_q;
  logic [7:0]        up_q;
  logic [3:0]        rlink_q;

  // Scan findings.
  logic              match_q;
  logic [SLOT_W-1:0] match_slot_q;
  logic              match_static_q;
  logic [2:0]        match_link_q;
  logic              free_q;
  logic [SLOT_W-1:0] free_slot_q;

  // Shared compare unit.
  logic              hit;
  logic [31:0]       age;
  logic              expired;

  // Finishing logic.
  logic              hop_drop;
  logic              is_local;
  logic              learn_ok;
  logic [3:0]        target;
  logic [3:0]        ingress_ext;
  res_t              base;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign last        = (idx_q == SLOT_W'(ROUTES - 1));
  assign rd_slot_o   = idx_q;
  assign ingress_ext = {1'b0, ingress_q};

  // Address match and age check of the slot under scan.
  assign hit     = rd_i.used && (rd_i.addr == addr_q);
  assign age     = now_q - rd_i.seen;
  assign expired = age > cfg_i.route_ttl_ms;

  // Sequencer: idle, one table slot a cycle, then result hand-off.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (last) state_d = ST_DONE;
      ST_DONE: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q   <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (!last) idx_q <= idx_q + 1'b1;
        if (hit && !match_q) match_q <= 1'b1;
        if (!rd_i.used && !free_q) free_q <= 1'b1;
      end
    end
  end

  // First matching and first free slot, kept with the entry fields needed later.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      if (hit && !match_q) begin
        match_slot_q   <= idx_q;
        match_static_q <= rd_i.is_static;
        match_link_q   <= rd_i.link;
      end
      if (!rd_i.used && !free_q) free_slot_q <= idx_q;
    end
  end

  // Item fields captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(op_i);
      addr_q     <= dest_addr_i[ADDR_W-1:0];
      ingress_q  <= ingress_link_i;
      hops_q     <= hop_count_i;
      upstream_q <= upstream_i;
      len_q      <= payload_len_i;
      now_q      <= now_ms_i;
      up_q       <= links_up_i;
      rlink_q    <= route_link_i;
    end
  end

  // Receive-side conditions.
  assign hop_drop = hops_q > cfg_i.max_hops;
  assign is_local = (cfg_i.local_addr[ADDR_W-1:0] != '0) &&
                    (addr_q == cfg_i.local_addr[ADDR_W-1:0]);
  assign learn_ok = (op_q == OP_RX) && !hop_drop && cfg_i.learn_enable && upstream_q &&
                    !is_local && (ingress_ext < NO_LINK) &&
                    (ingress_ext < cfg_i.link_count) &&
                    !cfg_i.uplink_mask[ingress_q] && (addr_q != '0);

  // Result and table update of the finished item; ageing writes during the scan.
  always_comb begin
    base   = '0;
    res_o  = '0;
    wr_o   = '0;
    target = NO_LINK;

    if (state_q == ST_SCAN && op_q == OP_TICK && cfg_i.route_ttl_ms != '0 &&
        rd_i.used && !rd_i.is_static && expired) begin
      wr_o.wr      = 1'b1;
      wr_o.slot    = idx_q;
      wr_o.wr_used = 1'b1;
      wr_o.used    = 1'b0;
    end

    case (op_q)
      OP_RX: begin
        if (hop_drop) begin
          res_o.action      = ACT_DROP;
          res_o.drop_reason = DROP_HOP_LIMIT;
        end else begin
          // Learning from upstream traffic.
          if (learn_ok) begin
            if (match_q) begin
              wr_o.slot    = match_slot_q;
              wr_o.wr_seen = 1'b1;
              wr_o.seen    = now_q;
              wr_o.wr_link = !match_static_q;
              wr_o.link    = ingress_q;
            end else if (free_q) begin
              wr_o.slot      = free_slot_q;
              wr_o.wr_used   = 1'b1;
              wr_o.used      = 1'b1;
              wr_o.wr_static = 1'b1;
              wr_o.is_static = 1'b0;
              wr_o.wr_addr   = 1'b1;
              wr_o.addr      = addr_q;
              wr_o.wr_link   = 1'b1;
              wr_o.link      = ingress_q;
              wr_o.wr_seen   = 1'b1;
              wr_o.seen      = now_q;
              base.learned      = 1'b1;
              base.learned_slot = 4'(free_slot_q);
            end else begin
              base.table_full = 1'b1;
            end
          end
          // Route lookup sees the table as left by learning.
          if (match_q) begin
            target = {1'b0, (learn_ok && !match_static_q) ? ingress_q : match_link_q};
          end else if (learn_ok && free_q) begin
            target = ingress_ext;
          end
          if (target == ingress_ext) target = NO_LINK;
          if (target == NO_LINK && cfg_i.default_link != ingress_ext) begin
            target = cfg_i.default_link;
          end
          if (is_local) begin
            res_o        = base;
            res_o.action = ACT_LOCAL;
          end else if (target == NO_LINK) begin
            res_o             = base;
            res_o.action      = ACT_DROP;
            res_o.drop_reason = DROP_NO_ROUTE;
          end else begin
            res_o = deliver(target, hops_q + 8'd1, len_q, up_q, cfg_i, base);
          end
        end
      end
      OP_SEND: begin
        target = match_q ? {1'b0, match_link_q} : cfg_i.default_link;
        res_o  = deliver(target, 8'd0, len_q, up_q, cfg_i, base);
      end
      OP_TICK: begin
        res_o = base;
      end
      default: begin
        // Static route insertion or update.
        if (addr_q == '0 || rlink_q >= NO_LINK || rlink_q >= cfg_i.link_count) begin
          res_o.route_status = RT_BAD_ARG;
        end else if (match_q) begin
          wr_o.slot      = match_slot_q;
          wr_o.wr_link   = 1'b1;
          wr_o.link      = rlink_q[2:0];
          wr_o.wr_static = 1'b1;
          wr_o.is_static = 1'b1;
        end else if (free_q) begin
          wr_o.slot      = free_slot_q;
          wr_o.wr_used   = 1'b1;
          wr_o.used      = 1'b1;
          wr_o.wr_addr   = 1'b1;
          wr_o.addr      = addr_q;
          wr_o.wr_link   = 1'b1;
          wr_o.link      = rlink_q[2:0];
          wr_o.wr_static = 1'b1;
          wr_o.is_static = 1'b1;
        end else begin
          res_o.table_full   = 1'b1;
          res_o.route_status = RT_FULL;
        end
      end
    endcase

    // Finishing writes happen once, in the cycle the result is handed over.
    if (state_q == ST_DONE && res_ready_i &&
        (wr_o.wr_used || wr_o.wr_static || wr_o.wr_addr || wr_o.wr_link || wr_o.wr_seen)) begin
      wr_o.wr = 1'b1;
    end
  end

  // The table is only written while ageing during a scan or when an item finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.wr |-> ((state_q == ST_DONE) && res_ready_i) ||
                ((state_q == ST_SCAN) && (op_q == OP_TICK)))
    else $error("table written outside its windows");

  // A new route is only reported when the scan found no existing one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.learned) |-> (op_q == OP_RX) && !match_q && free_q)
    else $error("learned reported with a matching route present");

  // An accepted item always starts its scan at the first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (idx_q == '0) && !match_q && !free_q)
    else $error("scan did not restart on a new item");

endmodule

>>> rtl/learning_frame_router.sv
// Frame router with a learned route table. After acceptance an item scans
// the table one slot per cycle through the single address compare and age
// unit, then finishes with a valid result; one item is handled at a time.
// The next item is taken while a result waits in the output register.
// Reset clears the route table's used marks and loads the register defaults.
// Depends on lfr_pkg, lfr_table and lfr_ctrl.
module learning_frame_router
  import lfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [31:0]        dest_addr_i,
  input  logic [2:0]         ingress_link_i,
  input  logic [7:0]         hop_count_i,
  input  logic               upstream_i,
  input  logic [9:0]         payload_len_i,
  input  logic [31:0]        now_ms_i,
  input  logic [7:0]         links_up_i,
  input  logic [3:0]         route_link_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         action_o,
  output logic [2:0]         out_link_o,
  output logic [7:0]         out_hops_o,
  output logic [2:0]         drop_reason_o,
  output logic               learned_o,
  output logic [3:0]         learned_slot_o,
  output logic               table_full_o,
  output logic [1:0]         route_status_o
);

  cfg_t              cfg_q;
  reg_e              reg_idx;
  logic              cfg_wr;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              res_q;
  logic              out_valid_q;
  logic [SLOT_W-1:0] rd_slot;
  tbl_rd_t           rd;
  tbl_wr_t           wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_addr   <= '0;
      cfg_q.learn_enable <= 1'b1;
      cfg_q.max_hops     <= 8'd8;
      cfg_q.route_ttl_ms <= '0;
      cfg_q.default_link <= NO_LINK;
      cfg_q.uplink_mask  <= '0;
      cfg_q.link_count   <= 4'(LINKS);
      cfg_q.mtu_bytes    <= 10'd1023;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LOCAL_ADDR:   cfg_q.local_addr   <= pwdata;
        REG_LEARN_ENABLE: cfg_q.learn_enable <= pwdata[0];
        REG_MAX_HOPS:     cfg_q.max_hops     <= pwdata[7:0];
        REG_ROUTE_TTL:    cfg_q.route_ttl_ms <= pwdata;
        REG_DEFAULT_LINK: cfg_q.default_link <= pwdata[3:0];
        REG_UPLINK_MASK:  cfg_q.uplink_mask  <= pwdata[7:0];
        REG_LINK_COUNT:   cfg_q.link_count   <= pwdata[3:0];
        REG_MTU_BYTES:    cfg_q.mtu_bytes    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LOCAL_ADDR:   prdata = cfg_q.local_addr;
      REG_LEARN_ENABLE: prdata = 32'(cfg_q.learn_enable);
      REG_MAX_HOPS:     prdata = 32'(cfg_q.max_hops);
      REG_ROUTE_TTL:    prdata = cfg_q.route_ttl_ms;
      REG_DEFAULT_LINK: prdata = 32'(cfg_q.default_link);
      REG_UPLINK_MASK:  prdata = 32'(cfg_q.uplink_mask);
      REG_LINK_COUNT:   prdata = 32'(cfg_q.link_count);
      REG_MTU_BYTES:    prdata = 32'(cfg_q.mtu_bytes);
      default:          prdata = '0;
    endcase
  end

  lfr_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_slot_i (rd_slot),
    .rd_o      (rd),
    .wr_i      (wr)
  );

  lfr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .dest_addr_i    (dest_addr_i),
    .ingress_link_i (ingress_link_i),
    .hop_count_i    (hop_count_i),
    .upstream_i     (upstream_i),
    .payload_len_i  (payload_len_i),
    .now_ms_i       (now_ms_i),
    .links_up_i     (links_up_i),
    .route_link_i   (route_link_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .rd_slot_o      (rd_slot),
    .rd_i           (rd),
    .wr_o           (wr)
  );

  // Output register: takes a new result when empty or being emptied.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) res_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = res_q.action;
  assign out_link_o     = res_q.out_link;
  assign out_hops_o     = res_q.out_hops;
  assign drop_reason_o  = res_q.drop_reason;
  assign learned_o      = res_q.learned;
  assign learned_slot_o = res_q.learned_slot;
  assign table_full_o   = res_q.table_full;
  assign route_status_o = res_q.route_status;

endmodule
